FILE: src/assert_macros.svh
// Assertion macros shared by the checker modules.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define MOM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define MOM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mom_pkg.sv
// Types and constants for the mask outer-outline marker.
// No dependencies; imported by every module of the block but mom_ram.
package mom_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_RIGHT    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_BOTTOM   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_VALUE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_FRAME   = 4'd7;

    // Item types
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] alpha_in;
    } in_item_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic        is_outline;
        logic [7:0]  alpha_out;
        logic        frame_end;
    } out_item_t;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [11:0] box_left;
        logic [11:0] box_top;
        logic [11:0] box_right;
        logic [11:0] box_bottom;
        logic [7:0]  mark_value;
        logic        full_frame;
    } cfg_regs_t;

    // Position and geometry of the pixel judged by one item
    typedef struct packed {
        logic        due;
        logic        in_window;
        logic        left_ok;
        logic        up_ok;
        logic        right_ok;
        logic        down_ok;
        logic        last;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } pos_info_t;

endpackage

FILE: src/mom_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mom_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/mom_pos.sv
// Input and output position counters, scan window geometry and frame end.
// Depends on mom_pkg.
module mom_pos #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  mom_pkg::in_item_t            item,
    input  mom_pkg::cfg_regs_t           cfg,
    output logic                         pix_bit,
    output logic [$clog2(MAX_WIDTH)-1:0] addr,
    output mom_pkg::pos_info_t           info
);
    import mom_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = CW + 1;
    localparam int CMPW = (WW > 13) ? WW : 13;

    logic [CW-1:0]   in_col_reg,  in_col_next;
    logic [12:0]     in_row_reg,  in_row_next;
    logic [CW-1:0]   out_col_reg, out_col_next;
    logic [11:0]     out_row_reg, out_row_next;

    logic [CMPW-1:0] wx, hx, cx, cy, lx, rx, tx, dx;
    logic            due, in_wrap, out_wrap;

    // Effective frame size: zero means one, width limited to the line store
    always_comb
    begin
        if (cfg.frame_width == '0)
        begin
            wx = CMPW'(1);
        end
        else if (CMPW'(cfg.frame_width) > CMPW'(MAX_WIDTH))
        begin
            wx = CMPW'(MAX_WIDTH);
        end
        else
        begin
            wx = CMPW'(cfg.frame_width);
        end
        hx = (cfg.frame_height == '0) ? CMPW'(1) : CMPW'(cfg.frame_height);
    end

    assign cx = CMPW'(out_col_reg);
    assign cy = CMPW'(out_row_reg);

    // Scan window: the whole image in full-frame mode, else the box with right and bottom edges clipped to the image
    always_comb
    begin
        if (cfg.full_frame)
        begin
            lx = '0;
            tx = '0;
            rx = wx - CMPW'(1);
            dx = hx - CMPW'(1);
        end
        else
        begin
            lx = CMPW'(cfg.box_left);
            tx = CMPW'(cfg.box_top);
            rx = (CMPW'(cfg.box_right) > wx - CMPW'(1)) ?
                 wx - CMPW'(1) : CMPW'(cfg.box_right);
            dx = (CMPW'(cfg.box_bottom) > hx - CMPW'(1)) ?
                 hx - CMPW'(1) : CMPW'(cfg.box_bottom);
        end
    end

    assign due = (in_row_reg >= 13'd2) || (in_row_reg == 13'd1 && in_col_reg != '0);

    assign pix_bit = (item.req_type == REQ_PIXEL) && (CMPW'(in_row_reg) < hx) &&
                     item.alpha_in[7];
    assign addr    = in_col_reg;

    always_comb
    begin
        info.due       = due;
        info.in_window = (cx >= lx) && (cx <= rx) && (cy >= tx) && (cy <= dx);
        info.left_ok   = (cx != '0);
        info.up_ok     = (cy != '0);
        info.right_ok  = (cx + CMPW'(1) < wx);
        info.down_ok   = (cy + CMPW'(1) < hx);
        info.last      = (cy >= hx - CMPW'(1)) && (cx >= wx - CMPW'(1));
        info.pixel_x   = 12'(out_col_reg);
        info.pixel_y   = out_row_reg;
    end

    assign in_wrap  = (CMPW'(in_col_reg) + CMPW'(1) >= wx);
    assign out_wrap = (cx + CMPW'(1) >= wx);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept)
        begin
            if (in_wrap)
            begin
                in_col_next = '0;
                if (in_row_reg != '1)
                begin
                    in_row_next = in_row_reg + 13'd1;
                end
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end

            if (due && info.last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (due)
            begin
                if (out_wrap)
                begin
                    out_col_next = '0;
                    if (out_row_reg != '1)
                    begin
                        out_row_next = out_row_reg + 12'd1;
                    end
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

FILE: src/mom_judge.sv
// 3x3 window of alpha bits, outline decision and the result register.
// Depends on mom_pkg.
module mom_judge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s1_valid,
    input  logic                s1_bit,
    input  logic [1:0]          line_bits,   // [1] two rows up, [0] one row up
    input  mom_pkg::pos_info_t  info,
    input  logic [7:0]          mark_value,
    input  logic                out_ready,
    output logic                advance,
    output logic                out_valid,
    output mom_pkg::out_item_t  out_data
);
    import mom_pkg::*;

    logic [8:0] window_reg, window_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;
    logic       slot_free, hit;

    // Newest column enters at the top: [8] current row, [7] one up, [6] two up
    assign window_next = {s1_bit, line_bits[0], line_bits[1], window_reg[8:3]};

    assign hit = info.in_window && !window_next[4] &&
                 ((info.left_ok  && window_next[1]) ||
                  (info.up_ok    && window_next[3]) ||
                  (info.right_ok && window_next[7]) ||
                  (info.down_ok  && window_next[5]));

    assign slot_free = !out_valid_reg || out_ready;
    assign advance   = s1_valid && (!info.due || slot_free);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && info.due)
        begin
            out_valid_next           = 1'b1;
            out_data_next.pixel_x    = info.pixel_x;
            out_data_next.pixel_y    = info.pixel_y;
            out_data_next.is_outline = hit;
            out_data_next.alpha_out  = hit ? mark_value : 8'd0;
            out_data_next.frame_end  = info.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                window_reg <= window_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/mask_outer_outline_marker.sv
// Top level of the mask outer-outline marker: configuration registers,
// line store, pipeline register. Depends on mom_pkg, mom_pos, mom_judge, mom_ram.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | sink      | in_valid / in_ready    | in_data   (mom_pkg::in_item_t)
//  out     | source    | out_valid / out_ready  | out_data  (mom_pkg::out_item_t)
//  cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while out does not stall. A transfer on in is registered
// in stage 1, judged there, and its result, if any, goes to the output register.
// Results lag the items by one row plus one pixel of the frame (line store
// plus window delay), not by clock cycles.
// Reset clears counters, window and handshake state; the line store holds
// garbage until written, which only feeds neighbours that are masked off.
// A stalled out channel holds the pipeline; in_ready follows out_ready
// directly, so no bubble is inserted when the consumer frees the register.
// cfg_ready is always high; registers are to be written by the user while the block is idle (not enforced).
module mask_outer_outline_marker #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mom_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mom_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mom_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mom_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mom_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // Configuration registers
    cfg_regs_t  cfg_reg, cfg_next;

    // Position stage outputs
    logic          pos_bit;
    logic [CW-1:0] pos_addr;
    pos_info_t     pos_info;

    // Judge stage register (one item in flight between the two sides)
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_bit_reg;
    logic [CW-1:0] s1_addr_reg;
    pos_info_t     s1_info_reg;
    logic          s1_byp_reg;
    logic [1:0]    s1_bypd_reg;

    logic          accept;
    logic          s1_adv;
    logic [1:0]    ram_rdata;
    logic [1:0]    line_bits;
    logic [1:0]    line_wdata;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data;
                CFG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data;
                CFG_BOX_LEFT:     cfg_next.box_left     = cfg_data[11:0];
                CFG_BOX_TOP:      cfg_next.box_top      = cfg_data[11:0];
                CFG_BOX_RIGHT:    cfg_next.box_right    = cfg_data[11:0];
                CFG_BOX_BOTTOM:   cfg_next.box_bottom   = cfg_data[11:0];
                CFG_MARK_VALUE:   cfg_next.mark_value   = cfg_data[7:0];
                CFG_FULL_FRAME:   cfg_next.full_frame   = cfg_data[0];
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= 13'd4096;
            cfg_reg.frame_height <= 13'd4096;
            cfg_reg.box_left     <= 12'd0;
            cfg_reg.box_top      <= 12'd0;
            cfg_reg.box_right    <= 12'd4095;
            cfg_reg.box_bottom   <= 12'd4095;
            cfg_reg.mark_value   <= 8'd255;
            cfg_reg.full_frame   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Position counters and window geometry, evaluated at the transfer
    // ------------------------------------------------------------------
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    mom_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (in_data),
        .cfg     (cfg_reg),
        .pix_bit (pos_bit),
        .addr    (pos_addr),
        .info    (pos_info)
    );

    // ------------------------------------------------------------------
    // Line store: entry {two rows up, one row up} per column.
    // Read at the transfer, written back when the item leaves stage 1.
    // A one-pixel-wide frame reads the column being written in the same
    // cycle, so that data is forwarded around the RAM.
    // ------------------------------------------------------------------
    assign line_bits  = s1_byp_reg ? s1_bypd_reg : ram_rdata;
    assign line_wdata = {line_bits[0], s1_bit_reg};

    mom_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (line_wdata),
        .rd_en   (accept),
        .rd_addr (pos_addr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 register
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bit_reg  <= pos_bit;
            s1_addr_reg <= pos_addr;
            s1_info_reg <= pos_info;
            s1_byp_reg  <= s1_valid_reg && s1_adv && (s1_addr_reg == pos_addr);
            s1_bypd_reg <= line_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Window, outline decision and result register
    // ------------------------------------------------------------------
    mom_judge u_judge (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid_reg),
        .s1_bit     (s1_bit_reg),
        .line_bits  (line_bits),
        .info       (s1_info_reg),
        .mark_value (cfg_reg.mark_value),
        .out_ready  (out_ready),
        .advance    (s1_adv),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

endmodule

FILE: src/mom_checker.sv
// Port-level checker for the mask outer-outline marker, bound to the top.
// Depends on mom_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mom_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  mom_pkg::in_item_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  mom_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mom_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mom_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mom_pkg::*;

    logic [7:0] mark_reg;
    logic       in_seen;

    // Shadow of the mark value register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 8'd255;
        end
        else if (cfg_valid && cfg_ready && cfg_index == CFG_MARK_VALUE)
        begin
            mark_reg <= cfg_data[7:0];
        end
    end

    assign in_seen = in_valid && (in_data.req_type == REQ_PIXEL || in_data.req_type == REQ_FLUSH);

    `MOM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
    `MOM_ASSERT_NOW(a_no_bubble, (!out_valid || out_ready) && in_seen, in_ready, "input stalled with free result slot")
    `MOM_ASSERT_NOW(a_mark_value, out_valid && out_data.is_outline, out_data.alpha_out == mark_reg, "outline pixel carries wrong mark")
    `MOM_ASSERT_NOW(a_plain_zero, out_valid && !out_data.is_outline, out_data.alpha_out == 8'd0, "unmarked pixel has nonzero alpha")

endmodule

bind mask_outer_outline_marker mom_checker u_mom_checker (.*);

FILE: dv/mom_tb_pkg.sv
// Outline scoreboard for the mask outer-outline marker testbench.
// Depends on mom_pkg for the item, result and register types.
package mom_tb_pkg;
    import mom_pkg::*;

    localparam int unsigned LINE_DEPTH = 4096;
    localparam int unsigned ROW_IN_SAT = 8191;
    localparam int unsigned ROW_OUT_SAT = 4095;

    class outline_scoreboard;
        cfg_regs_t   regs;
        bit          older_line [LINE_DEPTH];
        bit          newer_line [LINE_DEPTH];
        bit [8:0]    win;
        int unsigned in_col, in_row, out_col, out_row;
        out_item_t   marks_due [$];
        int unsigned errors;

        function new();
            regs = '{frame_width: 13'd4096, frame_height: 13'd4096,
                     box_left: 12'd0, box_top: 12'd0,
                     box_right: 12'd4095, box_bottom: 12'd4095,
                     mark_value: 8'd255, full_frame: 1'b0};
            win     = '0;
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            errors  = 0;
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = regs.frame_width;
            if (w == 0) w = 1;
            if (w > LINE_DEPTH) w = LINE_DEPTH;
            return w;
        endfunction

        function int unsigned eff_height();
            return (regs.frame_height == 0) ? 1 : int'(regs.frame_height);
        endfunction

        function int unsigned frame_pixels();
            return eff_width() * eff_height();
        endfunction

        function bit at_frame_start();
            return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
        endfunction

        function int unsigned outstanding();
            return marks_due.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FRAME_WIDTH:  regs.frame_width  = val;
                CFG_FRAME_HEIGHT: regs.frame_height = val;
                CFG_BOX_LEFT:     regs.box_left     = val[11:0];
                CFG_BOX_TOP:      regs.box_top      = val[11:0];
                CFG_BOX_RIGHT:    regs.box_right    = val[11:0];
                CFG_BOX_BOTTOM:   regs.box_bottom   = val[11:0];
                CFG_MARK_VALUE:   regs.mark_value   = val[7:0];
                CFG_FULL_FRAME:   regs.full_frame   = val[0];
                default: ;
            endcase
        endfunction

        // Advance the line stores and window by one transfer; queue the
        // judgement of the pixel one row plus one pixel behind, if due.
        function void note_item(in_item_t it);
            int unsigned w, h, lo_x, hi_x, lo_y, hi_y;
            bit          due, px, up2, up1, in_win, hit, last;
            out_item_t   res;
            w   = eff_width();
            h   = eff_height();
            due = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            px  = (it.req_type == REQ_PIXEL && in_row < h) ? it.alpha_in[7] : 1'b0;
            up2 = 1'b0;
            up1 = 1'b0;
            if (in_col < LINE_DEPTH) begin
                up2 = older_line[in_col];
                up1 = newer_line[in_col];
                older_line[in_col] = up1;
                newer_line[in_col] = px;
            end
            win = {px, up1, up2, win[8:3]};

            if (in_col + 1 >= w) begin
                in_col = 0;
                if (in_row < ROW_IN_SAT) in_row++;
            end else begin
                in_col++;
            end
            if (!due) return;

            if (regs.full_frame) begin
                lo_x = 0;
                hi_x = w - 1;
                lo_y = 0;
                hi_y = h - 1;
            end else begin
                lo_x = regs.box_left;
                lo_y = regs.box_top;
                hi_x = (regs.box_right > w - 1) ? w - 1 : int'(regs.box_right);
                hi_y = (regs.box_bottom > h - 1) ? h - 1 : int'(regs.box_bottom);
            end
            in_win = out_col >= lo_x && out_col <= hi_x && out_row >= lo_y && out_row <= hi_y;

            // centre bit 4; left 1, up 3, right 7, down 5
            hit = 1'b0;
            if (in_win && !win[4])
                hit = (out_col > 0 && win[1]) || (out_row > 0 && win[3]) ||
                      (out_col + 1 < w && win[7]) || (out_row + 1 < h && win[5]);
            last = out_row >= h - 1 && out_col >= w - 1;

            res.pixel_x    = out_col[11:0];
            res.pixel_y    = out_row[11:0];
            res.is_outline = hit;
            res.alpha_out  = hit ? regs.mark_value : 8'd0;
            res.frame_end  = last;
            marks_due.push_back(res);

            if (last) begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
            end else if (out_col + 1 >= w) begin
                out_col = 0;
                if (out_row < ROW_OUT_SAT) out_row++;
            end else begin
                out_col++;
            end
        endfunction

        function void flag(string field, logic [11:0] want, logic [11:0] got);
            errors++;
            $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (marks_due.size() == 0) begin
                errors++;
                $error("result at (%0d,%0d) with nothing expected", got.pixel_x, got.pixel_y);
                return;
            end
            want = marks_due.pop_front();
            if (got.pixel_x !== want.pixel_x) flag("pixel_x", want.pixel_x, got.pixel_x);
            if (got.pixel_y !== want.pixel_y) flag("pixel_y", want.pixel_y, got.pixel_y);
            if (got.is_outline !== want.is_outline)
                flag("is_outline", 12'(want.is_outline), 12'(got.is_outline));
            if (got.alpha_out !== want.alpha_out)
                flag("alpha_out", 12'(want.alpha_out), 12'(got.alpha_out));
            if (got.frame_end !== want.frame_end)
                flag("frame_end", 12'(want.frame_end), 12'(got.frame_end));
        endfunction
    endclass

endpackage

FILE: dv/tb_top.sv
// Top-level testbench for mask_outer_outline_marker: clock, reset, drivers and checks.
// Depends on mom_pkg (RTL types) and mom_tb_pkg (outline scoreboard).
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mom_pkg::*;
    import mom_tb_pkg::*;

    localparam int unsigned RUN_LIMIT       = 1000000;
    localparam int unsigned RANDOM_ITEMS    = 1650;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    // Index beyond the register map; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'hF;

    // Opening frame, 4 x 3: alpha extremes, a flush inside the frame (reads
    // as transparent), pixels in the drain (ignored), and one extra flush
    // that already belongs to the next frame.
    localparam in_item_t OPENING_SEQ [18] = '{
        '{REQ_PIXEL, 8'd0},   '{REQ_PIXEL, 8'd127}, '{REQ_PIXEL, 8'd128}, '{REQ_PIXEL, 8'd255},
        '{REQ_PIXEL, 8'd255}, '{REQ_PIXEL, 8'd0},   '{REQ_FLUSH, 8'd0},   '{REQ_PIXEL, 8'd127},
        '{REQ_PIXEL, 8'd0},   '{REQ_PIXEL, 8'd128}, '{REQ_PIXEL, 8'd0},   '{REQ_PIXEL, 8'd127},
        '{REQ_FLUSH, 8'd0},   '{REQ_PIXEL, 8'd255}, '{REQ_FLUSH, 8'd0},   '{REQ_FLUSH, 8'd0},
        '{REQ_PIXEL, 8'd128}, '{REQ_FLUSH, 8'd255}
    };

    typedef enum int unsigned {RX_FULL, RX_MOSTLY, RX_HALF, RX_PATTERN} rx_mode_e;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    outline_scoreboard sb;
    int unsigned       cycle_count  = 0;
    int unsigned       items_sent   = 0;
    int unsigned       burst_left   = 0;
    bit                hold_off_req = 1'b0;

    mask_outer_outline_marker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Watchdog: a run that stalls or loses results ends here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("FAIL mask_outer_outline_marker");
            $finish;
        end
    end

    // Every result transfer is checked against the oldest prediction.
    // Values read just after the edge are the ones the flops sampled.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Receiver: changes its stall pattern every so often, from no stalls at
    // all to a fixed on/off rhythm. A hold-off request parks out_ready low
    // for a long stretch so the block backs up and drops in_ready.
    initial begin : receiver
        rx_mode_e    mode;
        int unsigned span, period, on_len, phase;
        forever begin
            mode   = rx_mode_e'($urandom_range(0, 3));
            span   = $urandom_range(16, 160);
            period = $urandom_range(2, 5);
            on_len = $urandom_range(1, period - 1);
            phase  = 0;
            repeat (span) begin
                @(posedge clk);
                if (hold_off_req) begin
                    out_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    hold_off_req = 1'b0;
                end
                case (mode)
                    RX_FULL:    out_ready <= 1'b1;
                    RX_MOSTLY:  out_ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:    out_ready <= ($urandom_range(0, 1) != 0);
                    RX_PATTERN: out_ready <= ((phase % period) < on_len);
                    default:    out_ready <= 1'b1;
                endcase
                phase++;
            end
        end
    end

    // Alpha with a chosen share of opaque pixels; now and then an extreme
    function automatic logic [7:0] pick_alpha(input int unsigned opaque_pct);
        logic [7:0] a;
        a = 8'($urandom_range(0, 255));
        a[7] = ($urandom_range(0, 99) < opaque_pct);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       a = 8'd0;
                1:       a = 8'd127;
                2:       a = 8'd128;
                default: a = 8'd255;
            endcase
        end
        return a;
    endfunction

    // One transfer on the input channel. The sender works in bursts; between
    // bursts valid drops for a random gap. Valid stays high across
    // back-to-back transfers and is only lowered by a gap or a pause.
    task automatic offer(input logic kind, input logic [7:0] alpha);
        in_item_t    it;
        int unsigned gap;
        it.req_type = kind;
        it.alpha_in = alpha;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(it);
        items_sent++;
    endtask

    // Idle the sender until every predicted result has arrived, then allow
    // for a transfer still in flight that yields no result.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; program_regs lowers it after the last write
    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(input cfg_regs_t r);
        write_one(CFG_FRAME_WIDTH,  r.frame_width);
        write_one(CFG_FRAME_HEIGHT, r.frame_height);
        write_one(CFG_BOX_LEFT,     {1'b0, r.box_left});
        write_one(CFG_BOX_TOP,      {1'b0, r.box_top});
        write_one(CFG_BOX_RIGHT,    {1'b0, r.box_right});
        write_one(CFG_BOX_BOTTOM,   {1'b0, r.box_bottom});
        write_one(CFG_MARK_VALUE,   {5'b0, r.mark_value});
        write_one(CFG_FULL_FRAME,   {12'b0, r.full_frame});
        write_one(CFG_UNMAPPED,     13'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Drain: flushes (now and then an ignored pixel) until the frame_end
    // result has returned every counter to zero.
    task automatic close_frame();
        while (!sb.at_frame_start())
            offer(($urandom_range(0, 7) == 0) ? REQ_PIXEL : REQ_FLUSH, 8'($urandom));
    endtask

    // One frame of pixels plus its drain. Small frames are sometimes cut
    // short or overrun, and sometimes followed by stray flushes that start
    // the next frame early.
    task automatic run_frame(input int unsigned opaque_pct);
        int unsigned npix;
        npix = sb.frame_pixels();
        if (npix <= 200 && $urandom_range(0, 9) == 0)
            npix = $urandom_range(0, 2 * npix);
        repeat (npix) begin
            if ($urandom_range(0, 49) == 0)
                offer(REQ_FLUSH, 8'($urandom));
            else
                offer(REQ_PIXEL, pick_alpha(opaque_pct));
        end
        close_frame();
        if ($urandom_range(0, 11) == 0)
            repeat ($urandom_range(1, 3)) offer(REQ_FLUSH, 8'($urandom));
    endtask

    initial begin
        cfg_regs_t   r;
        int unsigned frame_no, base, w, h;

        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: small full-frame scan, box registers set to an empty
        // window that full-frame mode must override
        r = '{frame_width: 13'd4, frame_height: 13'd3, box_left: 12'd4095, box_top: 12'd4095,
              box_right: 12'd0, box_bottom: 12'd0, mark_value: 8'hA5, full_frame: 1'b1};
        program_regs(r);
        foreach (OPENING_SEQ[i])
            offer(OPENING_SEQ[i].req_type, OPENING_SEQ[i].alpha_in);

        // Random frames. The first few force zero width, zero height and
        // empty windows; the first reprogram lands mid-frame, since the
        // opening sequence left a stray flush behind.
        frame_no = 0;
        base     = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (frame_no < 4 || $urandom_range(0, 1) == 0) begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 10);
                if ($urandom_range(0, 9) == 0) w = $urandom_range(13, 40);
                if ($urandom_range(0, 19) == 0) w = 0;
                if ($urandom_range(0, 19) == 0) h = 0;
                if (frame_no == 0) w = 0;
                if (frame_no == 1) h = 0;
                r.frame_width  = 13'(w);
                r.frame_height = 13'(h);
                r.full_frame   = ($urandom_range(0, 1) != 0);
                r.box_left     = 12'($urandom_range(0, w));
                r.box_right    = 12'($urandom_range(0, w + 1));
                r.box_top      = 12'($urandom_range(0, h));
                r.box_bottom   = 12'($urandom_range(0, h + 1));
                if ($urandom_range(0, 7) == 0) r.box_right  = 12'hFFF;
                if ($urandom_range(0, 7) == 0) r.box_bottom = 12'hFFF;
                if ($urandom_range(0, 15) == 0) r.box_left  = 12'hFFF;
                if (frame_no == 2) begin
                    r.full_frame = 1'b0;
                    r.box_right  = 12'($urandom_range(0, w));
                    r.box_left   = r.box_right + 12'($urandom_range(1, 3));
                end
                if (frame_no == 3) begin
                    r.full_frame = 1'b0;
                    r.box_bottom = 12'($urandom_range(0, h));
                    r.box_top    = r.box_bottom + 12'($urandom_range(1, 3));
                end
                case ($urandom_range(0, 5))
                    0:       r.mark_value = 8'd0;
                    1:       r.mark_value = 8'd255;
                    default: r.mark_value = 8'($urandom);
                endcase
                pause_until_drained();
                program_regs(r);
            end
            if (frame_no == 6) hold_off_req = 1'b1;
            run_frame($urandom_range(15, 85));
            frame_no++;
        end
        close_frame();

        // A frame wide enough that results flow well before the long
        // receiver hold-off ends, so the block backs up and stalls its input.
        pause_until_drained();
        hold_off_req = 1'b1;
        r = '{frame_width: 13'd12, frame_height: 13'd4, box_left: 12'd0, box_top: 12'd0,
              box_right: 12'd4095, box_bottom: 12'd4095, mark_value: 8'd200, full_frame: 1'b1};
        program_regs(r);
        run_frame(50);

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS mask_outer_outline_marker");
        else
            $display("FAIL mask_outer_outline_marker");
        $finish;
    end

endmodule
